[sv/dnsd_pkg.sv]
// Shared types and constants of the DNS name decompressor.
package dnsd_pkg;

    // Request kinds
    localparam logic REQ_STORE  = 1'b0;
    localparam logic REQ_DECODE = 1'b1;

    // Completion status codes
    localparam logic [1:0] STAT_OK       = 2'd0;
    localparam logic [1:0] STAT_HOP_LIM  = 2'd1;
    localparam logic [1:0] STAT_TOO_LONG = 2'd2;

    // Label and pointer encoding
    localparam logic [1:0] PTR_TAG  = 2'b11;
    localparam logic [7:0] DOT_CHAR = 8'h2E;
    localparam logic [3:0] CHUNK_FULL = 4'd8;

    typedef struct packed {
        logic       req_type;
        logic [8:0] byte_addr;
        logic [7:0] byte_value;
    } req_word_t;

    typedef struct packed {
        logic [63:0] name_chunk;
        logic [3:0]  chunk_bytes;
        logic        last_chunk;
        logic [7:0]  name_length;
        logic [8:0]  advance;
        logic [1:0]  status;
    } rsp_word_t;

    typedef enum logic [4:0] {
        ST_IDLE = 5'b00001,
        ST_LEN  = 5'b00010,
        ST_PTR  = 5'b00100,
        ST_CHAR = 5'b01000,
        ST_DONE = 5'b10000
    } walk_state_t;

endpackage

[sv/dns_name_decompress_core.sv]
// Top level of the DNS name decompressor: packet store, label walker and result register.
//
//  channel | dir | handshake            | word
//  --------+-----+----------------------+----------------------------------------------
//  req     | in  | req_valid/req_ready  | req_word_t: store a byte or decode at offset
//  rsp     | out | rsp_valid/rsp_ready  | rsp_word_t: up to eight name characters per word
//
//  A store word is written straight into the packet RAM.
//  A decode word starts the walk, which reads each length byte, each name character
//  and both bytes of every compression pointer, then closes; the packet RAM read port
//  is the bottleneck, one byte per cycle unless stalled, with registered read data.
//  req_ready is high only between decodes; a waiting result word does not block it.
//  An undrained full result register stalls the walk at a full chunk and at its close;
//  the RAM read enable is dropped so the inspected byte stays on the read data lines.
//  Reset clears the walker and the result valid flag; the RAM holds no reset value.
//  PACKET_DEPTH must be a power of two so that address wrap is a plain truncation.
module dns_name_decompress_core
    import dnsd_pkg::*;
#(
    parameter int PACKET_DEPTH = 512,
    parameter int MAX_NAME_LEN = 255,
    parameter int MAX_HOPS     = 16
) (
    input  logic      clk,
    input  logic      rst_n,
    input  logic      req_valid,
    output logic      req_ready,
    input  req_word_t req,
    output logic      rsp_valid,
    input  logic      rsp_ready,
    output rsp_word_t rsp
);

    localparam int AW = $clog2(PACKET_DEPTH);

    // Walker state
    walk_state_t state_reg, state_next;
    logic [AW-1:0] pos_reg, pos_next;      // address of the byte now on the read lines
    logic [5:0]    rem_reg, rem_next;      // characters left in the current label
    logic [5:0]    hi_reg, hi_next;        // upper pointer bits, held for the second byte
    logic [63:0]   chunk_reg, chunk_next;
    logic [3:0]    cnt_reg, cnt_next;      // characters in chunk_reg
    logic [7:0]    chars_reg, chars_next;  // dotted length so far
    logic [8:0]    bytes_reg, bytes_next;  // bytes the name occupies in place
    logic          ptr_seen_reg, ptr_seen_next;
    logic [4:0]    hops_reg, hops_next;
    logic [1:0]    status_reg, status_next;

    // Result register
    logic      out_valid_reg, out_valid_next;
    rsp_word_t out_word_reg, out_word_next;

    // RAM port signals
    logic          ram_we;
    logic [AW-1:0] ram_wr_addr;
    logic          ram_rd_en;
    logic [AW-1:0] ram_rd_addr;
    logic [7:0]    ram_rd_data;

    logic [13:0]   req_addr_wide;
    logic [AW-1:0] req_addr;
    logic [13:0]   ptr_wide;
    logic [AW-1:0] pos_inc;
    logic          out_free;
    logic          app_stall;
    logic          do_append;
    logic [7:0]    app_char;
    logic          need_dot;

    dnsd_ram #(
        .WIDTH (8),
        .DEPTH (PACKET_DEPTH)
    ) u_store (
        .clk     (clk),
        .we      (ram_we),
        .wr_addr (ram_wr_addr),
        .wr_data (req.byte_value),
        .rd_en   (ram_rd_en),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_rd_data)
    );

    // Wrap every address into the store
    assign req_addr_wide = {5'b0, req.byte_addr};
    assign req_addr      = req_addr_wide[AW-1:0];
    assign ptr_wide      = {hi_reg, ram_rd_data};
    assign pos_inc       = pos_reg + AW'(1);

    assign out_free  = !out_valid_reg || rsp_ready;
    // A full chunk can only be pushed out when the result register has room
    assign app_stall = (cnt_reg == CHUNK_FULL) && !out_free;
    assign need_dot  = (chars_reg != 8'd0);

    always_comb
    begin
        state_next    = state_reg;
        pos_next      = pos_reg;
        rem_next      = rem_reg;
        hi_next       = hi_reg;
        chunk_next    = chunk_reg;
        cnt_next      = cnt_reg;
        chars_next    = chars_reg;
        bytes_next    = bytes_reg;
        ptr_seen_next = ptr_seen_reg;
        hops_next     = hops_reg;
        status_next   = status_reg;
        out_valid_next = out_valid_reg;
        out_word_next  = out_word_reg;

        req_ready   = 1'b0;
        ram_we      = 1'b0;
        ram_wr_addr = req_addr;
        ram_rd_en   = 1'b0;
        ram_rd_addr = pos_inc;
        do_append   = 1'b0;
        app_char    = ram_rd_data;

        // Drain the result register
        if (out_valid_reg && rsp_ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                req_ready = 1'b1;
                if (req_valid)
                begin
                    if (req.req_type == REQ_STORE)
                    begin
                        ram_we = 1'b1;
                    end
                    else
                    begin
                        pos_next      = req_addr;
                        ram_rd_en     = 1'b1;
                        ram_rd_addr   = req_addr;
                        chunk_next    = '0;
                        cnt_next      = '0;
                        chars_next    = '0;
                        bytes_next    = '0;
                        ptr_seen_next = 1'b0;
                        hops_next     = '0;
                        status_next   = STAT_OK;
                        state_next    = ST_LEN;
                    end
                end
            end

            ST_LEN:
            begin
                if (ram_rd_data[7:6] == PTR_TAG)
                begin
                    if (!ptr_seen_reg)
                    begin
                        bytes_next    = bytes_reg + 9'd2;
                        ptr_seen_next = 1'b1;
                    end
                    if (hops_reg >= 5'(MAX_HOPS))
                    begin
                        status_next = STAT_HOP_LIM;
                        state_next  = ST_DONE;
                    end
                    else
                    begin
                        hops_next  = hops_reg + 5'd1;
                        hi_next    = ram_rd_data[5:0];
                        ram_rd_en  = 1'b1;
                        state_next = ST_PTR;
                    end
                end
                else if (ram_rd_data[5:0] == 6'd0)
                begin
                    if (!ptr_seen_reg)
                    begin
                        bytes_next = bytes_reg + 9'd1;
                    end
                    status_next = STAT_OK;
                    state_next  = ST_DONE;
                end
                else if (need_dot && (chars_reg >= 8'(MAX_NAME_LEN)))
                begin
                    status_next = STAT_TOO_LONG;
                    state_next  = ST_DONE;
                end
                else if (!(need_dot && app_stall))
                begin
                    if (!ptr_seen_reg)
                    begin
                        bytes_next = bytes_reg + 9'd1 + {3'b0, ram_rd_data[5:0]};
                    end
                    do_append  = need_dot;
                    app_char   = DOT_CHAR;
                    rem_next   = ram_rd_data[5:0];
                    pos_next   = pos_inc;
                    ram_rd_en  = 1'b1;
                    state_next = ST_CHAR;
                end
            end

            ST_PTR:
            begin
                // Follow the pointer: full 14-bit offset, wrapped into the store
                pos_next    = ptr_wide[AW-1:0];
                ram_rd_en   = 1'b1;
                ram_rd_addr = ptr_wide[AW-1:0];
                state_next  = ST_LEN;
            end

            ST_CHAR:
            begin
                if (chars_reg >= 8'(MAX_NAME_LEN))
                begin
                    status_next = STAT_TOO_LONG;
                    state_next  = ST_DONE;
                end
                else if (!app_stall)
                begin
                    do_append = 1'b1;
                    rem_next  = rem_reg - 6'd1;
                    pos_next  = pos_inc;
                    ram_rd_en = 1'b1;
                    if (rem_reg == 6'd1)
                    begin
                        state_next = ST_LEN;
                    end
                end
            end

            ST_DONE:
            begin
                if (out_free)
                begin
                    out_valid_next            = 1'b1;
                    out_word_next.name_chunk  = chunk_reg;
                    out_word_next.chunk_bytes = cnt_reg;
                    out_word_next.last_chunk  = 1'b1;
                    out_word_next.name_length = chars_reg;
                    out_word_next.advance     = (status_reg == STAT_OK) ? bytes_reg : 9'd0;
                    out_word_next.status      = status_reg;
                    state_next                = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        // Append one character; push out a full chunk first
        if (do_append)
        begin
            chars_next = chars_reg + 8'd1;
            if (cnt_reg == CHUNK_FULL)
            begin
                out_valid_next            = 1'b1;
                out_word_next.name_chunk  = chunk_reg;
                out_word_next.chunk_bytes = CHUNK_FULL;
                out_word_next.last_chunk  = 1'b0;
                out_word_next.name_length = 8'd0;
                out_word_next.advance     = 9'd0;
                out_word_next.status      = STAT_OK;
                chunk_next                = {56'b0, app_char};
                cnt_next                  = 4'd1;
            end
            else
            begin
                chunk_next[{cnt_reg[2:0], 3'b000} +: 8] = app_char;
                cnt_next                                = cnt_reg + 4'd1;
            end
        end
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            rem_reg       <= '0;
            cnt_reg       <= '0;
            chars_reg     <= '0;
            bytes_reg     <= '0;
            ptr_seen_reg  <= 1'b0;
            hops_reg      <= '0;
            status_reg    <= STAT_OK;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            rem_reg       <= rem_next;
            cnt_reg       <= cnt_next;
            chars_reg     <= chars_next;
            bytes_reg     <= bytes_next;
            ptr_seen_reg  <= ptr_seen_next;
            hops_reg      <= hops_next;
            status_reg    <= status_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload
    always_ff @(posedge clk)
    begin
        pos_reg      <= pos_next;
        hi_reg       <= hi_next;
        chunk_reg    <= chunk_next;
        out_word_reg <= out_word_next;
    end

    assign rsp_valid = out_valid_reg;
    assign rsp       = out_word_reg;

endmodule

[sv/dnsd_ram.sv]
// Generic single-write, single-read RAM with registered read data.
module dnsd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 512
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

[tb/sv/dnsd_result_checker.sv]
`timescale 1ns / 1ps
// Checker of the DNS name decompressor: shadows the packet store, predicts and compares result words.
module dnsd_result_checker
    import dnsd_pkg::*;
#(
    parameter int NAME_MAX = 255,
    parameter int HOP_MAX  = 16
) (
    input  logic      clk,
    input  logic      rst_n,
    input  logic      req_valid,
    input  logic      req_ready,
    input  req_word_t req,
    input  logic      rsp_valid,
    input  logic      rsp_ready,
    input  rsp_word_t rsp,
    output int        fail_count,
    output int        words_pending
);

    logic [7:0] shadow_pkt [512];
    rsp_word_t  expected_words [$];

    initial begin
        fail_count    = 0;
        words_pending = 0;
    end

    // Walk the name at start in the shadow store and queue the words it yields.
    task automatic predict_name_words(input logic [8:0] start);
        logic [7:0] name_text [256];
        logic [8:0] pos;
        logic [7:0] len_byte;
        logic [1:0] stat;
        rsp_word_t  w;
        int n_chars, in_place, hops, label_len, n_words, cnt, k, i;
        bit via_ptr, done;
        pos      = start;
        n_chars  = 0;
        in_place = 0;
        hops     = 0;
        via_ptr  = 1'b0;
        done     = 1'b0;
        stat     = STAT_OK;
        while (!done) begin
            len_byte = shadow_pkt[pos];
            if (len_byte[7:6] == PTR_TAG) begin
                if (!via_ptr) begin
                    in_place += 2;
                    via_ptr = 1'b1;
                end
                if (hops >= HOP_MAX) begin
                    stat = STAT_HOP_LIM;
                    done = 1'b1;
                end else begin
                    hops++;
                    pos = {len_byte[0], shadow_pkt[pos + 9'd1]};
                end
            end else begin
                label_len = len_byte[5:0];
                if (label_len == 0) begin
                    if (!via_ptr)
                        in_place += 1;
                    done = 1'b1;
                end else begin
                    if (!via_ptr)
                        in_place += 1 + label_len;
                    if (n_chars > 0) begin
                        if (n_chars >= NAME_MAX) begin
                            stat = STAT_TOO_LONG;
                            done = 1'b1;
                        end else begin
                            name_text[n_chars] = DOT_CHAR;
                            n_chars++;
                        end
                    end
                    pos = pos + 9'd1;
                    while (!done && label_len > 0) begin
                        if (n_chars >= NAME_MAX) begin
                            stat = STAT_TOO_LONG;
                            done = 1'b1;
                        end else begin
                            name_text[n_chars] = shadow_pkt[pos];
                            n_chars++;
                            pos = pos + 9'd1;
                            label_len--;
                        end
                    end
                end
            end
        end
        n_words = (n_chars + 7) / 8;
        if (n_words == 0)
            n_words = 1;
        for (k = 0; k < n_words; k++) begin
            cnt = n_chars - 8 * k;
            if (cnt > 8)
                cnt = 8;
            if (cnt < 0)
                cnt = 0;
            w = '0;
            for (i = 0; i < cnt; i++)
                w.name_chunk[8 * i +: 8] = name_text[8 * k + i];
            w.chunk_bytes = cnt[3:0];
            if (k == n_words - 1) begin
                w.last_chunk  = 1'b1;
                w.name_length = n_chars[7:0];
                w.advance     = (stat == STAT_OK) ? in_place[8:0] : 9'd0;
                w.status      = stat;
            end
            expected_words.push_back(w);
        end
    endtask

    task automatic check_field(input string fname, input logic [63:0] want,
                               input logic [63:0] got);
        if (want !== got) begin
            $error("%s: expected %0h, got %0h", fname, want, got);
            fail_count++;
        end
    endtask

    always @(posedge clk) begin
        rsp_word_t want;
        if (rst_n) begin
            if (req_valid && req_ready) begin
                if (req.req_type == REQ_STORE)
                    shadow_pkt[req.byte_addr] = req.byte_value;
                else
                    predict_name_words(req.byte_addr);
            end
            if (rsp_valid && rsp_ready) begin
                if (expected_words.size() == 0) begin
                    $error("result word with nothing expected: %h", rsp);
                    fail_count++;
                end else begin
                    want = expected_words.pop_front();
                    check_field("name_chunk", want.name_chunk, rsp.name_chunk);
                    check_field("chunk_bytes", want.chunk_bytes, rsp.chunk_bytes);
                    check_field("last_chunk", want.last_chunk, rsp.last_chunk);
                    check_field("name_length", want.name_length, rsp.name_length);
                    check_field("advance", want.advance, rsp.advance);
                    check_field("status", want.status, rsp.status);
                end
            end
            words_pending = expected_words.size();
        end
    end

endmodule

[tb/sv/tb_top.sv]
`timescale 1ns / 1ps
// Testbench top of the DNS name decompressor: clock, reset, request and result traffic, verdict.
module tb_top;
    import dnsd_pkg::*;

    localparam int NAME_MAX    = 255;
    localparam int HOP_MAX     = 16;
    localparam int RAND_WORDS  = 200;   // request words in the random part
    localparam int MIN_DECODES = 40;    // keep going until this many random decodes
    localparam int HOLD_CYCLES = 400;   // long result stall, fills the block

    logic      clk = 1'b0;
    logic      rst_n;
    logic      req_valid;
    logic      req_ready;
    req_word_t req;
    logic      rsp_valid;
    logic      rsp_ready;
    rsp_word_t rsp;

    int fail_count;
    int words_pending;

    // Idle odds in percent for each side, and the phase that sets them
    int tx_idle_pct = 10;
    int rx_idle_pct = 48;
    int idle_phase  = 0;

    int words_sent = 0;
    int decodes_sent = 0;

    // Byte image of the packet store, written in full before any decode so that
    // no walk ever touches an entry that was never written
    logic [7:0] layout [512];

    dns_name_decompress_core #(
        .PACKET_DEPTH(512),
        .MAX_NAME_LEN(NAME_MAX),
        .MAX_HOPS    (HOP_MAX)
    ) uut (
        .clk      (clk),
        .rst_n    (rst_n),
        .req_valid(req_valid),
        .req_ready(req_ready),
        .req      (req),
        .rsp_valid(rsp_valid),
        .rsp_ready(rsp_ready),
        .rsp      (rsp)
    );

    dnsd_result_checker #(
        .NAME_MAX(NAME_MAX),
        .HOP_MAX (HOP_MAX)
    ) checker_i (
        .clk          (clk),
        .rst_n        (rst_n),
        .req_valid    (req_valid),
        .req_ready    (req_ready),
        .req          (req),
        .rsp_valid    (rsp_valid),
        .rsp_ready    (rsp_ready),
        .rsp          (rsp),
        .fail_count   (fail_count),
        .words_pending(words_pending)
    );

    always #5 clk = ~clk;

    // Hard stop well beyond the slowest correct run
    initial
    begin
        #(3_000_000);
        $display("Simulation FAILED");
        $finish;
    end

    function automatic req_word_t store_word(input logic [8:0] addr, input logic [7:0] val);
        req_word_t w;
        w.req_type   = REQ_STORE;
        w.byte_addr  = addr;
        w.byte_value = val;
        return w;
    endfunction

    // Decode words carry a random byte_value: the block must ignore it
    function automatic req_word_t decode_word(input logic [8:0] addr);
        req_word_t w;
        w.req_type   = REQ_DECODE;
        w.byte_addr  = addr;
        w.byte_value = $urandom_range(0, 255);
        return w;
    endfunction

    // Place a compression pointer to target at slot in the store image
    task automatic put_pointer(input logic [8:0] slot, input logic [8:0] target);
        logic [8:0] next_slot;
        next_slot          = slot + 9'd1;
        layout[slot]      = {PTR_TAG, 5'b00000, target[8]};
        layout[next_slot] = target[7:0];
    endtask

    // Offer one word and hold it until accepted; idle beforehand at random.
    // Lowering valid happens only in idle cycles, so a back-to-back word keeps
    // valid high with a single assignment per edge.
    task automatic send_word(input req_word_t w);
        while ($urandom_range(0, 99) < tx_idle_pct) begin
            req_valid <= 1'b0;
            @(posedge clk);
        end
        req_valid <= 1'b1;
        req       <= w;
        @(posedge clk);
        while (!req_ready)
            @(posedge clk);
        words_sent++;
        if (w.req_type == REQ_DECODE)
            decodes_sent++;
    endtask

    // Result side: random stalls, plus one long hold-off at the start of the
    // second idle phase while the sender keeps offering words
    initial
    begin
        int  hold_left;
        bit  held;
        hold_left = 0;
        held      = 1'b0;
        rsp_ready <= 1'b0;
        forever begin
            @(posedge clk);
            if (idle_phase == 1 && !held) begin
                held      = 1'b1;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                rsp_ready <= 1'b0;
            end else begin
                rsp_ready <= ($urandom_range(0, 99) >= rx_idle_pct);
            end
        end
    end

    initial
    begin
        logic [8:0] base, pos, prev_base, target;
        logic [7:0] hdr;
        logic [4:0] high_bits;
        int a, l, c, n_labels, len, kind, tail, choice, rand_start;

        req_valid <= 1'b0;
        req       <= '0;
        rst_n     <= 1'b0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Build the store image: random filler with hand-placed names on top
        for (a = 0; a < 512; a++)
            layout[a] = $urandom_range(0, 255);
        // label that runs across the top of the store into address 0
        layout[505] = 8'd8;
        layout[2]   = 8'd0;
        // four 63-byte labels, then a pointer: the dot after them is one too many
        for (l = 0; l < 4; l++)
            layout[3 + 64 * l] = 8'd63;
        put_pointer(9'd259, 9'd352);
        // pointer to itself: runs into the hop limit
        put_pointer(9'd300, 9'd300);
        // chain of pointers: sixteen hops from 320, seventeen from 318
        for (l = 0; l <= 16; l++)
            put_pointer(9'(318 + 2 * l), 9'(320 + 2 * l));
        layout[352] = 8'd3;
        layout[356] = 8'd0;
        // pointer with the spare offset bits set, lands on 352 once wrapped
        layout[360] = 8'hFF;
        layout[361] = 8'h60;
        // reserved label types 01 and 10 taken as plain labels, then a pointer
        layout[370] = 8'h43;
        layout[374] = 8'h82;
        put_pointer(9'd377, 9'd352);
        // empty names: plain zero byte, and a reserved type with length zero
        layout[400] = 8'd0;
        layout[402] = 8'h40;

        for (a = 0; a < 512; a++)
            send_word(store_word(a[8:0], layout[a]));

        // Directed decodes over the hand-placed names
        send_word(decode_word(9'd3));
        send_word(store_word(9'd259, 8'd0));   // now exactly the longest name
        send_word(decode_word(9'd3));
        send_word(decode_word(9'd505));
        send_word(decode_word(9'd300));
        send_word(decode_word(9'd320));
        send_word(decode_word(9'd318));
        send_word(decode_word(9'd360));
        send_word(decode_word(9'd370));
        send_word(decode_word(9'd400));
        send_word(decode_word(9'd402));
        send_word(store_word(9'd511, 8'd0));
        send_word(decode_word(9'd511));
        send_word(decode_word(9'd505));        // label now holds a zero character
        send_word(store_word(9'd511, 8'hFF));  // pointer whose low byte sits at 0
        send_word(decode_word(9'd511));

        // Random part: mostly freshly written names with random content, the
        // rest stray decodes, stray stores and names left unterminated
        rand_start   = words_sent;
        decodes_sent = 0;
        prev_base    = 9'd352;
        while (words_sent - rand_start < RAND_WORDS || decodes_sent < MIN_DECODES) begin
            idle_phase = (words_sent - rand_start) / (RAND_WORDS / 3);
            if (idle_phase > 2)
                idle_phase = 2;
            case (idle_phase)
                0: begin tx_idle_pct = 10; rx_idle_pct = 48; end
                1: begin tx_idle_pct = 48; rx_idle_pct = 10; end
                default: begin tx_idle_pct = 0; rx_idle_pct = 0; end
            endcase

            choice = $urandom_range(0, 99);
            if (choice < 70) begin
                base     = $urandom_range(0, 511);
                pos      = base;
                n_labels = $urandom_range(1, 3);
                for (l = 0; l < n_labels; l++) begin
                    len  = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 63)
                                                       : $urandom_range(1, 8);
                    kind = $urandom_range(0, 9);
                    hdr  = {(kind == 0) ? 2'b01 : (kind == 1) ? 2'b10 : 2'b00, 6'(len)};
                    send_word(store_word(pos, hdr));
                    pos = pos + 9'd1;
                    for (c = 0; c < len; c++) begin
                        send_word(store_word(pos, 8'($urandom_range(0, 255))));
                        pos = pos + 9'd1;
                    end
                end
                tail      = $urandom_range(0, 99);
                high_bits = $urandom_range(0, 31);
                if (tail < 45) begin
                    send_word(store_word(pos, 8'd0));
                end else if (tail < 85) begin
                    // point back at an earlier name, or anywhere at all
                    target = (tail < 70) ? prev_base : 9'($urandom_range(0, 511));
                    send_word(store_word(pos, {PTR_TAG, high_bits, target[8]}));
                    send_word(store_word(pos + 9'd1, target[7:0]));
                end else if (tail < 92) begin
                    send_word(store_word(pos, {($urandom_range(0, 1) ? 2'b01 : 2'b10),
                                               6'd0}));
                end
                send_word(decode_word(base));
                prev_base = base;
            end else if (choice < 85) begin
                send_word(decode_word(9'($urandom_range(0, 511))));
            end else begin
                send_word(store_word(9'($urandom_range(0, 511)),
                                     8'($urandom_range(0, 255))));
            end
        end
        req_valid <= 1'b0;

        // Drain: let the last decode register, wait for every result, then settle
        @(posedge clk);
        while (words_pending != 0)
            @(posedge clk);
        repeat (50) @(posedge clk);

        if (fail_count == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule

[dns_name_decompress_core.f]
sv/dnsd_pkg.sv
sv/dnsd_ram.sv
sv/dns_name_decompress_core.sv
tb/sv/dnsd_result_checker.sv
tb/sv/tb_top.sv
